/* hw/rtl/rdgs_pkg.sv */
// Types, codes and fixed-point constants of the reaction-diffusion grid step.
// No dependencies; imported by reaction_diffusion_grid_step.
package rdgs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SETUP,
        ST_MUL,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_X2,
        OP_X2Y,
        OP_REACT,
        OP_DECAY,
        OP_XROW,
        OP_XCOL,
        OP_YROW,
        OP_YCOL,
        OP_DTX,
        OP_DTY
    } t_op;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS,
        CFG_GRID_COLS,
        CFG_TIME_STEP,
        CFG_X_COEF_ROW,
        CFG_X_COEF_COL,
        CFG_Y_COEF_ROW,
        CFG_Y_COEF_COL
    } t_cfg_reg;

    // Neighbour taps, in read order
    localparam logic [2:0] TAP_CTR = 3'd0;
    localparam logic [2:0] TAP_UP  = 3'd1;
    localparam logic [2:0] TAP_DN  = 3'd2;
    localparam logic [2:0] TAP_LF  = 3'd3;
    localparam logic [2:0] TAP_RT  = 3'd4;
    localparam logic [2:0] TAP_END = 3'd5;

    // Reaction constants; the feed terms reduce to exact Q24.24 values
    localparam logic signed [63:0] KQ_B      = 64'sd109951162778;
    localparam logic signed [63:0] KQ_C      = 64'sd542969;
    localparam logic signed [63:0] FEED_X    = 64'sd167772160;
    localparam logic signed [63:0] FEED_Y    = 64'sd1342177280;
    localparam logic signed [63:0] LIM60     = 64'sd1152921504606846976;
    localparam logic signed [64:0] MAX48     = 65'sd140737488355327;
    localparam logic signed [64:0] MIN48     = -65'sd140737488355328;

    function automatic logic [1:0] dec3(input logic [1:0] m);
        return (m == 2'd0) ? 2'd2 : m - 2'd1;
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] m);
        return (m == 2'd2) ? 2'd0 : m + 2'd1;
    endfunction

    function automatic logic signed [63:0] clamp60(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > LIM60) r = LIM60;
        if (v < -LIM60) r = -LIM60;
        return r;
    endfunction

    function automatic logic [47:0] sat48(input logic signed [64:0] v);
        logic signed [64:0] r;
        r = v;
        if (v > MAX48) r = MAX48;
        if (v < MIN48) r = MIN48;
        return r[47:0];
    endfunction

endpackage

/* hw/rtl/reaction_diffusion_grid_step.sv */
// One explicit Euler step of a Schnakenberg reaction-diffusion grid.
// Depends on rdgs_pkg (state, op and register codes, constants, helpers).
//
//  channel | direction | handshake               | payload
//  in      | sink      | i_in_valid / o_in_ready  | i_x_value, i_y_value
//  out     | source    | o_out_valid / i_out_ready| o_x_next, o_y_next, flags
//  cfg     | sink      | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// An input transaction that causes no result leaves the sequencer idle. Each
// result passes through the five line-buffer reads, then ten products
// through one 32x32 multiplier (setup, multiply steps for the four partial
// products, rounding), then the output load.
// The final cell of the grid flushes its whole row.
// Reset is synchronous; line buffers are not cleared. A held result stalls
// the sequencer only when the next result is ready to load.
module reaction_diffusion_grid_step #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [47:0]                i_x_value,
    input  logic signed [47:0]                i_y_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [47:0]                o_x_next,
    output logic signed [47:0]                o_y_next,
    output logic                              o_last_of_run,
    output logic                              o_end_of_frame,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rdgs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rdgs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rdgs_pkg::*;

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ECW   = $clog2(MAX_COLS + 1);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ERW   = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = 3 * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    // configuration
    logic [10:0] r_cfg_rows;
    logic [5:0]  r_cfg_cols;
    logic [31:0] r_dt;
    logic [39:0] r_xk_row, r_xk_col, r_yk_row, r_yk_col;

    // position and job control
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [1:0]    r_rmod;
    logic [1:0]    r_emod, r_upmod, r_dnmod, r_fmod, r_fup;
    logic [CW-1:0] r_ej;
    logic          r_in_flush, r_pend_flush;
    logic [2:0]    r_rd;
    logic [2:0]    r_k;
    t_op           r_op;
    logic          r_out_valid;

    // line buffers
    logic [47:0] r_x_mem [DEPTH];
    logic [47:0] r_y_mem [DEPTH];
    logic signed [47:0] r_rdx, r_rdy;

    // datapath
    logic signed [47:0]  r_x, r_y;
    logic signed [50:0]  r_xr, r_xcl, r_yr, r_ycl;
    logic signed [63:0]  r_x2, r_x2y, r_dx, r_dy;
    logic [63:0]         r_ma, r_mb;
    logic                r_neg, r_sh40;
    logic [127:0]        r_acc;
    logic [63:0]         r_prod;
    logic [1:0]          r_pshift;
    logic [47:0]         r_xn, r_yn;
    logic signed [47:0]  r_out_x, r_out_y;
    logic                r_out_last, r_out_eof;

    logic [ERW-1:0] rows;
    logic [ECW-1:0] cols;
    logic           in_acc, cfg_acc, out_load, wrap, is_last, col_last, more;
    logic [RW-1:0]  cur_row;
    logic [CW-1:0]  cur_col;
    logic [1:0]     cur_mod;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic [CW-1:0]  lf_col, rt_col;
    logic signed [63:0] op_a, op_b, fin_res;
    logic [63:0]    fin_mag;
    logic [127:0]   acc_sh;
    logic           op_sh40;

    function automatic logic [AW-1:0] slot(input logic [1:0] m, input logic [CW-1:0] c);
        return AW'(m) * AW'(MAX_COLS) + AW'(c);
    endfunction

    always_comb begin
        if (r_cfg_rows == 11'd0) begin
            rows = ERW'(1);
        end else if (32'(r_cfg_rows) > MAX_ROWS) begin
            rows = ERW'(MAX_ROWS);
        end else begin
            rows = ERW'(r_cfg_rows);
        end
        if (r_cfg_cols == 6'd0) begin
            cols = ECW'(1);
        end else if (32'(r_cfg_cols) > MAX_COLS) begin
            cols = ECW'(MAX_COLS);
        end else begin
            cols = ECW'(r_cfg_cols);
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid;
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    assign wrap    = (ERW'(r_row) >= rows) || (ECW'(r_col) >= cols);
    assign cur_row = wrap ? '0 : r_row;
    assign cur_col = wrap ? '0 : r_col;
    assign cur_mod = wrap ? 2'd0 : r_rmod;
    assign is_last = (ERW'(cur_row) == rows - ERW'(1)) && (ECW'(cur_col) == cols - ECW'(1));
    assign wr_addr = slot(cur_mod, cur_col);

    assign col_last = (ECW'(r_ej) == cols - ECW'(1));
    assign more     = r_pend_flush || (r_in_flush && !col_last);
    assign lf_col   = (r_ej != '0) ? r_ej - CW'(1) : r_ej;
    assign rt_col   = (ECW'(r_ej) + ECW'(1) < cols) ? r_ej + CW'(1) : r_ej;

    always_comb begin
        unique case (r_rd)
            TAP_UP:  rd_addr = slot(r_upmod, r_ej);
            TAP_DN:  rd_addr = slot(r_dnmod, r_ej);
            TAP_LF:  rd_addr = slot(r_emod, lf_col);
            TAP_RT:  rd_addr = slot(r_emod, rt_col);
            default: rd_addr = slot(r_emod, r_ej);
        endcase
    end

    // operand selection for the shared multiplier
    always_comb begin
        op_sh40 = 1'b0;
        unique case (r_op)
            OP_X2:    begin op_a = 64'(r_x);   op_b = 64'(r_x); end
            OP_X2Y:   begin op_a = r_x2;       op_b = 64'(r_y); end
            OP_REACT: begin op_a = KQ_C;       op_b = r_x2y; op_sh40 = 1'b1; end
            OP_DECAY: begin op_a = KQ_B;       op_b = 64'(r_x); op_sh40 = 1'b1; end
            OP_XROW:  begin op_a = 64'(r_xk_row); op_b = 64'(r_xr); end
            OP_XCOL:  begin op_a = 64'(r_xk_col); op_b = 64'(r_xcl); end
            OP_YROW:  begin op_a = 64'(r_yk_row); op_b = 64'(r_yr); end
            OP_YCOL:  begin op_a = 64'(r_yk_col); op_b = 64'(r_ycl); end
            OP_DTX:   begin op_a = 64'(r_dt);  op_b = clamp60(r_dx); end
            OP_DTY:   begin op_a = 64'(r_dt);  op_b = clamp60(r_dy); end
            default:  begin op_a = '0;         op_b = '0; end
        endcase
    end

    // round already folded into the accumulator; shift, saturate, sign
    assign acc_sh  = r_sh40 ? (r_acc >> 40) : (r_acc >> 24);
    assign fin_mag = (acc_sh > 128'(LIM60)) ? LIM60 : acc_sh[63:0];
    assign fin_res = r_neg ? -$signed(fin_mag) : $signed(fin_mag);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc && (cur_row != '0 || is_last)) n_state = ST_READ;
            ST_READ:  if (r_rd == TAP_END) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_MUL;
            ST_MUL:   if (r_k == 3'd4) n_state = ST_FIN;
            ST_FIN:   n_state = (r_op == OP_DTY) ? ST_OUT : ST_SETUP;
            ST_OUT:   if (out_load) n_state = more ? ST_READ : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows   <= 11'd32;
            r_cfg_cols   <= 6'd32;
            r_dt         <= 32'd167772;
            r_xk_row     <= 40'd4194304;
            r_xk_col     <= 40'd4194304;
            r_yk_row     <= 40'd209715200;
            r_yk_col     <= 40'd209715200;
            r_row        <= '0;
            r_col        <= '0;
            r_rmod       <= 2'd0;
            r_emod       <= 2'd0;
            r_upmod      <= 2'd0;
            r_dnmod      <= 2'd0;
            r_fmod       <= 2'd0;
            r_fup        <= 2'd0;
            r_ej         <= '0;
            r_in_flush   <= 1'b0;
            r_pend_flush <= 1'b0;
            r_rd         <= '0;
            r_k          <= '0;
            r_op         <= OP_X2;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd <= (r_state == ST_READ) ? r_rd + 3'd1 : 3'd0;
            r_k  <= (r_state == ST_MUL) ? r_k + 3'd1 : 3'd0;
            if (r_state == ST_READ) r_op <= OP_X2;
            if (r_state == ST_FIN && r_op != OP_DTY) r_op <= t_op'(r_op + 4'd1);

            if (in_acc) begin
                // advance the raster position
                if (is_last) begin
                    r_row  <= '0;
                    r_col  <= '0;
                    r_rmod <= 2'd0;
                end else if (ECW'(cur_col) + ECW'(1) < cols) begin
                    r_row  <= cur_row;
                    r_col  <= cur_col + CW'(1);
                    r_rmod <= cur_mod;
                end else begin
                    r_row  <= cur_row + RW'(1);
                    r_col  <= '0;
                    r_rmod <= inc3(cur_mod);
                end
                r_fmod <= cur_mod;
                r_fup  <= (cur_row != '0) ? dec3(cur_mod) : cur_mod;
                if (cur_row != '0) begin
                    r_emod       <= dec3(cur_mod);
                    r_upmod      <= (cur_row > RW'(1)) ? dec3(dec3(cur_mod)) : dec3(cur_mod);
                    r_dnmod      <= cur_mod;
                    r_ej         <= cur_col;
                    r_in_flush   <= 1'b0;
                    r_pend_flush <= is_last;
                end else begin
                    // row zero: in a single row grid the last cell flushes row zero at once
                    r_emod       <= cur_mod;
                    r_upmod      <= cur_mod;
                    r_dnmod      <= cur_mod;
                    r_ej         <= '0;
                    r_in_flush   <= is_last;
                    r_pend_flush <= 1'b0;
                end
            end

            if (out_load) begin
                if (r_pend_flush) begin
                    r_emod       <= r_fmod;
                    r_upmod      <= r_fup;
                    r_dnmod      <= r_fmod;
                    r_ej         <= '0;
                    r_in_flush   <= 1'b1;
                    r_pend_flush <= 1'b0;
                end else if (r_in_flush && !col_last) begin
                    r_ej <= r_ej + CW'(1);
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_GRID_ROWS: begin
                        r_cfg_rows <= i_cfg_data[10:0];
                        r_row      <= '0;
                        r_col      <= '0;
                        r_rmod     <= 2'd0;
                    end
                    CFG_GRID_COLS: begin
                        r_cfg_cols <= i_cfg_data[5:0];
                        r_row      <= '0;
                        r_col      <= '0;
                        r_rmod     <= 2'd0;
                    end
                    CFG_TIME_STEP:  r_dt     <= i_cfg_data[31:0];
                    CFG_X_COEF_ROW: r_xk_row <= i_cfg_data;
                    CFG_X_COEF_COL: r_xk_col <= i_cfg_data;
                    CFG_Y_COEF_ROW: r_yk_row <= i_cfg_data;
                    CFG_Y_COEF_COL: r_yk_col <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x_mem[wr_addr] <= i_x_value;
            r_y_mem[wr_addr] <= i_y_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdx <= r_x_mem[rd_addr];
        r_rdy <= r_y_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_dx <= FEED_X;
            r_dy <= FEED_Y;
            unique case (r_rd)
                TAP_UP: begin
                    r_x <= r_rdx;
                    r_y <= r_rdy;
                end
                TAP_DN: begin
                    r_xr <= 51'(r_rdx) - (51'(r_x) <<< 1);
                    r_yr <= 51'(r_rdy) - (51'(r_y) <<< 1);
                end
                TAP_LF: begin
                    r_xr <= r_xr + 51'(r_rdx);
                    r_yr <= r_yr + 51'(r_rdy);
                end
                TAP_RT: begin
                    r_xcl <= 51'(r_rdx) - (51'(r_x) <<< 1);
                    r_ycl <= 51'(r_rdy) - (51'(r_y) <<< 1);
                end
                TAP_END: begin
                    r_xcl <= r_xcl + 51'(r_rdx);
                    r_ycl <= r_ycl + 51'(r_rdy);
                end
                default: ;
            endcase
        end

        if (r_state == ST_SETUP) begin
            r_ma   <= op_a[63] ? 64'(-op_a) : 64'(op_a);
            r_mb   <= op_b[63] ? 64'(-op_b) : 64'(op_b);
            r_neg  <= op_a[63] ^ op_b[63];
            r_sh40 <= op_sh40;
            r_acc  <= op_sh40 ? (128'd1 << 39) : (128'd1 << 23);
        end

        if (r_state == ST_MUL) begin
            // issue partial product k, accumulate the one before
            if (r_k != 3'd0) begin
                r_acc <= r_acc + (128'(r_prod) << {r_pshift, 5'd0});
            end
            r_prod   <= 64'(r_k[0] ? r_ma[63:32] : r_ma[31:0])
                      * 64'(r_k[1] ? r_mb[63:32] : r_mb[31:0]);
            r_pshift <= 2'({1'b0, r_k[0]} + {1'b0, r_k[1]});
        end

        if (r_state == ST_FIN) begin
            unique case (r_op)
                OP_X2:    r_x2  <= fin_res;
                OP_X2Y:   r_x2y <= fin_res;
                OP_REACT: begin
                    r_dx <= r_dx + fin_res;
                    r_dy <= r_dy - fin_res;
                end
                OP_DECAY: r_dx <= r_dx - fin_res;
                OP_XROW, OP_XCOL: r_dx <= r_dx + fin_res;
                OP_YROW, OP_YCOL: r_dy <= r_dy + fin_res;
                OP_DTX:   r_xn <= sat48(65'(r_x) + 65'(fin_res));
                OP_DTY:   r_yn <= sat48(65'(r_y) + 65'(fin_res));
                default: ;
            endcase
        end

        if (out_load) begin
            r_out_x    <= r_xn;
            r_out_y    <= r_yn;
            r_out_last <= !more;
            r_out_eof  <= r_in_flush && col_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_x_next       = r_out_x;
    assign o_y_next       = r_out_y;
    assign o_last_of_run  = r_out_last;
    assign o_end_of_frame = r_out_eof;

`ifndef SYNTHESIS
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_last_of_run)
        else $error("end of frame without last of run");

    a_flush_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_flush && r_pend_flush))
        else $error("flush running and pending at once");

    a_fin_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> ($past(r_state) == ST_MUL))
        else $error("rounding step without product");

    a_fin_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (fin_mag <= LIM60))
        else $error("product magnitude above limit");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten");
`endif

endmodule
